@@ rtl/spq_pkg.sv @@
// Shared types and codes for the sorted priority queue.
// No dependencies; imported by every module of the block but spq_ram.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

   localparam int CAP_W = 7;
   localparam int VALUE_W = 32;
   localparam logic [CAP_W-1:0] CAPACITY_RESET = 7'd64;

   typedef enum logic {
      OP_ENQ = 1'b0,
      OP_DEQ = 1'b1
   } spq_op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } spq_status_type;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_DEQ   = 5'b00010,
      S_CMP   = 5'b00100,
      S_PLACE = 5'b01000,
      S_DONE  = 5'b10000
   } spq_state_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;   // latch request, set up insertion pointers, issue first read
      logic shift;    // move read word up one slot
      logic rd_next;  // read the next lower slot
      logic place;    // write new value at insertion slot
      logic deq;      // take head word, free its slot
      logic load;     // move result into output register
   } spq_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic full;
      logic empty;
      logic gt;         // word read is greater than new value
      logic steps_one;  // last word left to compare
   } spq_stat_type;

endpackage

`default_nettype wire

@@ rtl/spq_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module spq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

@@ rtl/spq_datapath.sv @@
// Datapath: ring-buffer storage kept sorted, pointers, count, capacity, result regs.
// Depends on spq_pkg and spq_ram.
`timescale 1ns / 1ps
`default_nettype none

module spq_datapath import spq_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_we,
   input  wire logic [CAP_W-1:0]             csr_wdata,
   input  wire logic                         req_opcode,
   input  wire logic signed [VALUE_W-1:0]    req_value,
   input  wire spq_cmd_type                  cmd,
   output spq_stat_type                      stat,
   output logic signed [VALUE_W-1:0]         rsp_result_value,
   output logic [1:0]                        rsp_status,
   output logic [$clog2(DEPTH+1)-1:0]        rsp_occupancy
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;
   localparam int LW = (CW > CAP_W) ? CW : CAP_W;
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

   function automatic logic [AW-1:0] prev_slot(input logic [AW-1:0] a);
      return (a == '0) ? LAST_SLOT : a - 1'b1;
   endfunction

   logic [CAP_W-1:0]          capacity_ff, capacity_in;
   logic [AW-1:0]             head_ff, head_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [AW-1:0]             pos_ff, pos_in;
   logic [AW-1:0]             pm1_ff, pm1_in;
   logic [CW-1:0]             steps_ff, steps_in;
   logic signed [VALUE_W-1:0] x_ff, x_in;
   logic signed [VALUE_W-1:0] res_value_ff, res_value_in;
   spq_status_type            res_status_ff, res_status_in;
   logic signed [VALUE_W-1:0] out_value_ff, out_value_in;
   spq_status_type            out_status_ff, out_status_in;
   logic [CW-1:0]             out_occ_ff, out_occ_in;

   logic [SW-1:0]             tail_sum;
   logic [AW-1:0]             tail;
   logic [LW-1:0]             limit;
   logic [VALUE_W-1:0]        rdata;
   logic                      ram_we;
   logic [VALUE_W-1:0]        ram_wdata;
   logic                      ram_re;
   logic [AW-1:0]             ram_raddr;

   // tail slot = (head + count) mod DEPTH; sum stays below 2*DEPTH
   assign tail_sum = SW'(head_ff) + SW'(count_ff);
   assign tail = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);

   // capacity saturates at DEPTH
   assign limit = (LW'(capacity_ff) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(capacity_ff);

   assign stat.full      = (LW'(count_ff) >= limit);
   assign stat.empty     = (count_ff == '0);
   assign stat.gt        = ($signed(rdata) > x_ff);
   assign stat.steps_one = (steps_ff == CW'(1));

   // single write address: insertion slot
   assign ram_we    = cmd.shift | cmd.place;
   assign ram_wdata = cmd.shift ? rdata : x_ff;
   assign ram_re    = cmd.accept | cmd.rd_next;
   assign ram_raddr = cmd.accept ? ((req_opcode == OP_DEQ) ? head_ff : prev_slot(tail))
                                 : prev_slot(pm1_ff);

   spq_ram #(
      .WIDTH(VALUE_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (pos_ff),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (rdata)
   );

   always_comb begin
      capacity_in   = csr_we ? csr_wdata : capacity_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      pm1_in        = pm1_ff;
      steps_in      = steps_ff;
      x_in          = x_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      out_value_in  = out_value_ff;
      out_status_in = out_status_ff;
      out_occ_in    = out_occ_ff;

      if (cmd.accept) begin
         x_in         = req_value;
         pos_in       = tail;
         pm1_in       = prev_slot(tail);
         steps_in     = count_ff;
         res_value_in = '0;
         if (req_opcode == OP_DEQ) begin
            res_status_in = stat.empty ? ST_EMPTY : ST_OK;
         end else begin
            res_status_in = stat.full ? ST_FULL : ST_OK;
         end
      end
      if (cmd.shift) begin
         pos_in   = pm1_ff;
         pm1_in   = prev_slot(pm1_ff);
         steps_in = steps_ff - 1'b1;
      end
      if (cmd.place) begin
         count_in = count_ff + 1'b1;
      end
      if (cmd.deq) begin
         res_value_in = $signed(rdata);
         head_in      = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
         count_in     = count_ff - 1'b1;
      end
      if (cmd.load) begin
         out_value_in  = res_value_ff;
         out_status_in = res_status_ff;
         out_occ_in    = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
         head_ff     <= '0;
         count_ff    <= '0;
      end else begin
         capacity_ff <= capacity_in;
         head_ff     <= head_in;
         count_ff    <= count_in;
      end
      pos_ff        <= pos_in;
      pm1_ff        <= pm1_in;
      steps_ff      <= steps_in;
      x_ff          <= x_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      out_value_ff  <= out_value_in;
      out_status_ff <= out_status_in;
      out_occ_ff    <= out_occ_in;
   end

   assign rsp_result_value = out_value_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_occupancy    = out_occ_ff;

endmodule

`default_nettype wire

@@ rtl/spq_ctrl.sv @@
// Controller: sequences insertion shifts, dequeue reads and result hand-off.
// Depends on spq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spq_ctrl import spq_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic         req_opcode,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   input  wire spq_stat_type stat,
   output spq_cmd_type       cmd
);

   spq_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_opcode == OP_DEQ) begin
                  state_in = stat.empty ? S_DONE : S_DEQ;
               end else if (stat.full) begin
                  state_in = S_DONE;
               end else begin
                  state_in = stat.empty ? S_PLACE : S_CMP;
               end
            end
         end
         S_DEQ: begin
            cmd.deq  = 1'b1;
            state_in = S_DONE;
         end
         S_CMP: begin
            if (stat.gt) begin
               cmd.shift   = 1'b1;
               cmd.rd_next = ~stat.steps_one;
               state_in    = stat.steps_one ? S_PLACE : S_CMP;
            end else begin
               cmd.place = 1'b1;
               state_in  = S_DONE;
            end
         end
         S_PLACE: begin
            cmd.place = 1'b1;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ rtl/sorted_priority_queue_top.sv @@
// Sorted min priority queue: top level joining controller and datapath.
// Depends on spq_pkg, spq_ctrl, spq_datapath (which holds spq_ram).
//
// Usage:
//   req_* : one word per item; req_opcode 0 enqueues req_value, 1 dequeues
//           the smallest entry. Equal values leave in arrival order.
//   rsp_* : one word per item: dequeued value (zero otherwise), status
//           (ok / full-dropped / empty) and occupancy after the item.
//   csr_we/csr_wdata : capacity register, reset 64, saturates at DEPTH.
//           Write only while the block is idle.
// Sequence: a refused enqueue or an empty dequeue goes straight to the done
//   state; a dequeue reads the head word first; an enqueue shifts up each held
//   entry greater than the new value (one shift per cycle through the storage
//   RAM's single read and write port), then places the new value.
// The next item is taken the cycle after the result of the last one enters
//   the output register. Storage is a ring, so a dequeue moves no data; it
//   only advances the head pointer and lowers the count.
// Reset: queue empty, capacity 64. Storage contents are not cleared; only
//   data read from slots holding live entries is ever used.
// Stall: a result waits in the output register while rsp_ready is low; the
//   block still accepts and works the next item, then holds until that
//   register frees up.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue_top import spq_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_we,
   input  wire logic [CAP_W-1:0]             csr_wdata,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic                         req_opcode,
   input  wire logic signed [VALUE_W-1:0]    req_value,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic signed [VALUE_W-1:0]         rsp_result_value,
   output logic [1:0]                        rsp_status,
   output logic [$clog2(DEPTH+1)-1:0]        rsp_occupancy
);

   localparam int CW = $clog2(DEPTH + 1);

   spq_cmd_type  cmd;
   spq_stat_type stat;

   spq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   spq_datapath #(
      .DEPTH(DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .req_opcode       (req_opcode),
      .req_value        (req_value),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status),
      .rsp_occupancy    (rsp_occupancy)
   );

   // occupancy never exceeds storage depth
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_occupancy <= CW'(DEPTH)))
      else $error("occupancy above depth");

   // refused items carry a zero value
   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_FULL || rsp_status == ST_EMPTY))
         |-> (rsp_result_value == '0))
      else $error("nonzero value on refused item");

   // empty status only with nothing held
   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_EMPTY) |-> (rsp_occupancy == '0))
      else $error("empty status with entries held");

   // no new item accepted back to back after another
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second item accepted back to back");

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking bench for sorted_priority_queue_top: directed table, then random phases.
// Depends on spq_pkg and the RTL below sorted_priority_queue_top; a local shadow queue
// predicts every response word that the directed table does not give by hand.
`timescale 1ns / 1ps

module testbench;
   import spq_pkg::*;

   localparam int DEPTH = 64;
   localparam int OCC_W = $clog2(DEPTH + 1);
   // Slowest enqueue shifts every held entry once, plus a little slack.
   localparam int SETTLE_CYCLES = DEPTH + 8;
   localparam int CYCLE_LIMIT = 400000;
   localparam int N_PHASE = 9;
   localparam int PHASE_CAP [N_PHASE] = '{64, 5, 127, 1, 64, 0, 127, 17, 64};
   localparam int PHASE_LEN [N_PHASE] = '{100, 90, 110, 60, 100, 30, 110, 90, 110};

   typedef struct {
      logic signed [VALUE_W-1:0] value;
      spq_status_type            status;
      logic [OCC_W-1:0]          occ;
   } reply_type;

   typedef enum {ROW_WORD, ROW_CAP} row_kind_type;

   typedef struct {
      row_kind_type              kind;
      spq_op_type                op;
      logic signed [VALUE_W-1:0] value;
      logic [CAP_W-1:0]          cap;
      bit                        typed;   // want holds a hand-written reply
      reply_type                 want;
   } dir_row_type;

   // Directed sequence. Rows without a typed reply take theirs from the shadow queue.
   localparam int N_DIR = 27;
   dir_row_type directed [N_DIR] = '{
      '{ROW_WORD, OP_DEQ, 32'sd0,          7'd0,   1'b1, '{32'sd0, ST_EMPTY, 7'd0}},
      '{ROW_WORD, OP_ENQ, 32'sh7FFFFFFF,   7'd0,   1'b1, '{32'sd0, ST_OK, 7'd1}},
      '{ROW_WORD, OP_ENQ, 32'sh80000000,   7'd0,   1'b1, '{32'sd0, ST_OK, 7'd2}},
      '{ROW_WORD, OP_ENQ, 32'sd0,          7'd0,   1'b0, '{32'sd0, ST_OK, 7'd0}},
      '{ROW_WORD, OP_ENQ, 32'sd0,          7'd0,   1'b0, '{32'sd0, ST_OK, 7'd0}},
      '{ROW_WORD, OP_ENQ, -32'sd1,         7'd0,   1'b0, '{32'sd0, ST_OK, 7'd0}},
      // value is a don't-care on dequeue
      '{ROW_WORD, OP_DEQ, 32'sh5A5A5A5A,   7'd0,   1'b1, '{32'sh80000000, ST_OK, 7'd4}},
      '{ROW_WORD, OP_DEQ, -32'sd1,         7'd0,   1'b0, '{32'sd0, ST_OK, 7'd0}},
      '{ROW_WORD, OP_DEQ, 32'sd0,          7'd0,   1'b0, '{32'sd0, ST_OK, 7'd0}},
      '{ROW_WORD, OP_DEQ, 32'sd0,          7'd0,   1'b0, '{32'sd0, ST_OK, 7'd0}},
      '{ROW_WORD, OP_DEQ, 32'sd0,          7'd0,   1'b1, '{32'sh7FFFFFFF, ST_OK, 7'd0}},
      '{ROW_WORD, OP_DEQ, 32'sd0,          7'd0,   1'b1, '{32'sd0, ST_EMPTY, 7'd0}},
      // capacity zero refuses every enqueue
      '{ROW_CAP,  OP_ENQ, 32'sd0,          7'd0,   1'b0, '{32'sd0, ST_OK, 7'd0}},
      '{ROW_WORD, OP_ENQ, 32'sd5,          7'd0,   1'b1, '{32'sd0, ST_FULL, 7'd0}},
      '{ROW_CAP,  OP_ENQ, 32'sd0,          7'd1,   1'b0, '{32'sd0, ST_OK, 7'd0}},
      '{ROW_WORD, OP_ENQ, 32'sd5,          7'd0,   1'b0, '{32'sd0, ST_OK, 7'd0}},
      '{ROW_WORD, OP_ENQ, 32'sd3,          7'd0,   1'b1, '{32'sd0, ST_FULL, 7'd1}},
      // above DEPTH saturates
      '{ROW_CAP,  OP_ENQ, 32'sd0,          7'd127, 1'b0, '{32'sd0, ST_OK, 7'd0}},
      '{ROW_WORD, OP_ENQ, 32'sd3,          7'd0,   1'b0, '{32'sd0, ST_OK, 7'd0}},
      // lowered below count: nothing lost, enqueues refused until drained
      '{ROW_CAP,  OP_ENQ, 32'sd0,          7'd1,   1'b0, '{32'sd0, ST_OK, 7'd0}},
      '{ROW_WORD, OP_ENQ, 32'sd9,          7'd0,   1'b1, '{32'sd0, ST_FULL, 7'd2}},
      '{ROW_WORD, OP_DEQ, 32'sd0,          7'd0,   1'b0, '{32'sd0, ST_OK, 7'd0}},
      '{ROW_WORD, OP_ENQ, 32'sd9,          7'd0,   1'b1, '{32'sd0, ST_FULL, 7'd1}},
      '{ROW_WORD, OP_DEQ, 32'sd0,          7'd0,   1'b0, '{32'sd0, ST_OK, 7'd0}},
      '{ROW_WORD, OP_ENQ, 32'sd9,          7'd0,   1'b0, '{32'sd0, ST_OK, 7'd0}},
      '{ROW_WORD, OP_DEQ, 32'sd0,          7'd0,   1'b0, '{32'sd0, ST_OK, 7'd0}},
      '{ROW_CAP,  OP_ENQ, 32'sd0,          7'd64,  1'b0, '{32'sd0, ST_OK, 7'd0}}
   };

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      csr_we = 1'b0;
   logic [CAP_W-1:0]          csr_wdata = '0;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_opcode = OP_ENQ;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [VALUE_W-1:0] rsp_result_value;
   logic [1:0]                rsp_status;
   logic [OCC_W-1:0]          rsp_occupancy;

   // 0: sender idles 29%, receiver 54%; 1: swapped; 2: no idling
   int idle_mode = 0;
   int mismatches = 0;
   int cycles = 0;

   // Shadow queue: sorted ascending in slots 0..held-1
   logic signed [VALUE_W-1:0] sorted_vals [DEPTH];
   int                        held = 0;
   logic [CAP_W-1:0]          cap_shadow = CAPACITY_RESET;
   reply_type                 replies_due [$];
   reply_type                 no_reply = '{32'sd0, ST_OK, '0};

   sorted_priority_queue_top #(.DEPTH(DEPTH)) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status),
      .rsp_occupancy    (rsp_occupancy)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Applies one word to the shadow queue and returns the reply it earns.
   function automatic reply_type sorted_queue_apply(spq_op_type op,
                                                    logic signed [VALUE_W-1:0] v);
      reply_type r;
      int        limit;
      int        pos;
      r.value = '0;
      r.status = ST_OK;
      limit = (cap_shadow > DEPTH) ? DEPTH : int'(cap_shadow);
      if (op == OP_ENQ) begin
         if (held >= limit) begin
            r.status = ST_FULL;
         end else begin
            // land after every entry <= v so ties keep arrival order
            pos = held;
            while (pos > 0 && sorted_vals[pos-1] > v) begin
               sorted_vals[pos] = sorted_vals[pos-1];
               pos--;
            end
            sorted_vals[pos] = v;
            held++;
         end
      end else if (held == 0) begin
         r.status = ST_EMPTY;
      end else begin
         r.value = sorted_vals[0];
         for (int i = 1; i < held; i++)
            sorted_vals[i-1] = sorted_vals[i];
         held--;
      end
      r.occ = OCC_W'(held);
      return r;
   endfunction

   // Drives one request word; valid is held until the handshake completes.
   task automatic send_word(spq_op_type op, logic signed [VALUE_W-1:0] v,
                            bit typed, reply_type want);
      reply_type predicted;
      @(negedge clock);
      while ((idle_mode == 0 && $urandom_range(0, 99) < 29) ||
             (idle_mode == 1 && $urandom_range(0, 99) < 54)) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_value <= v;
      do @(posedge clock); while (!req_ready);
      predicted = sorted_queue_apply(op, v);
      replies_due.push_back(typed ? want : predicted);
   endtask

   // Drop valid and wait until every reply is back.
   task automatic quiesce(int settle);
      @(negedge clock);
      req_valid <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] cap);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= cap;
      cap_shadow = cap;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Stimulus
   initial begin
      spq_op_type                op;
      logic signed [VALUE_W-1:0] v;
      int                        fill_goal;
      int                        offset;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         if (directed[i].kind == ROW_CAP) begin
            quiesce(0);
            write_capacity(directed[i].cap);
         end else begin
            send_word(directed[i].op, directed[i].value, directed[i].typed,
                      directed[i].want);
         end
      end

      // Random phases: opcodes steer occupancy toward a moving fill goal so the
      // queue walks between empty and full; one word in ten ignores the goal.
      fill_goal = 0;
      for (int ph = 0; ph < N_PHASE; ph++) begin
         quiesce(0);
         write_capacity(CAP_W'(PHASE_CAP[ph]));
         idle_mode = ph / 3;
         for (int n = 0; n < PHASE_LEN[ph]; n++) begin
            if (n % 48 == 0 || held == fill_goal)
               fill_goal = $urandom_range(0, DEPTH + 8);
            if ($urandom_range(0, 9) == 0)
               op = spq_op_type'($urandom_range(0, 1));
            else
               op = (held < fill_goal) ? OP_ENQ : OP_DEQ;
            // mix of extremes, a narrow band full of ties, and full-range values
            case ($urandom_range(0, 7))
               0: begin
                  case ($urandom_range(0, 3))
                     0: v = 32'sh80000000;
                     1: v = 32'sh7FFFFFFF;
                     2: v = 32'sd0;
                     default: v = -32'sd1;
                  endcase
               end
               1, 2, 3: begin
                  offset = $urandom_range(0, 16);
                  v = offset - 8;
               end
               default: v = $urandom;
            endcase
            send_word(op, v, 1'b0, no_reply);
         end
      end

      quiesce(SETTLE_CYCLES);
      if (mismatches == 0 && replies_due.size() == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

   // Receiver backpressure
   always @(negedge clock) begin
      rsp_ready <= !((idle_mode == 0 && $urandom_range(0, 99) < 54) ||
                     (idle_mode == 1 && $urandom_range(0, 99) < 29));
   end

   // Response checker: in-order compare against the oldest due reply
   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (replies_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: value=%0d status=%0d occupancy=%0d",
                        rsp_result_value, rsp_status, rsp_occupancy);
         end else begin
            want = replies_due.pop_front();
            if (rsp_result_value !== want.value || rsp_status !== want.status ||
                rsp_occupancy !== want.occ) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected value=%0d status=%0d occupancy=%0d,",
                           want.value, want.status, want.occ,
                           " got value=%0d status=%0d occupancy=%0d",
                           rsp_result_value, rsp_status, rsp_occupancy);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

endmodule
